FILE: rtl/core/tcw_pkg.sv
// Shared types and constants for the text console writer.
// Holds request/response payload structs, character codes and default geometry.
// No dependencies.
package tcw_pkg;

    // default screen geometry
    localparam int COLUMNS_DEF = 80;
    localparam int ROWS_DEF    = 25;

    // fixed field widths
    localparam int CURSOR_W = 11;
    localparam int INDEX_W  = 11;

    // cell encoding: attribute in the high byte, character in the low byte
    localparam logic [15:0] BLANK_CELL   = 16'h0720;
    localparam logic [7:0]  CH_NEWLINE   = 8'd10;
    localparam logic [7:0]  CH_BACKSPACE = 8'd8;
    localparam logic [7:0]  CH_SPACE     = 8'h20;

    // request kinds
    localparam logic REQ_PRINT = 1'b0;
    localparam logic REQ_READ  = 1'b1;

    typedef struct packed {
        logic                req_type;
        logic [7:0]          char_code;
        logic [7:0]          color;
        logic [INDEX_W-1:0]  cell_index;
    } req_t;

    typedef struct packed {
        logic [7:0]          read_char;
        logic [7:0]          read_attr;
        logic [CURSOR_W-1:0] cursor_now;
        logic                scrolled;
    } rsp_t;

endpackage

FILE: rtl/core/text_console_writer_top.sv
// Print without scroll: response registered in the cycle after the transfer;
// read: synchronous screen memory read, then response register.
// Flow: one print per cycle while no response is held stalled; a read stalls
// new requests until its response is loaded; a scroll copies the screen one cell
// per cycle through the single memory. Reset: cursor and floor go to 0, then a
// clearing pass writes 0x0720 to every cell, with req_stall held high.
// Text console writer: screen cell memory, cursor/floor tracking, scroll sweep.
// Depends on tcw_pkg.
module text_console_writer_top
    import tcw_pkg::*;
#(
    parameter int COLUMNS = COLUMNS_DEF,
    parameter int ROWS    = ROWS_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    localparam int CELLS    = COLUMNS * ROWS;
    localparam int LAST_ROW = (ROWS - 1) * COLUMNS;
    localparam int AW       = $clog2(CELLS);
    localparam int CW       = $clog2(COLUMNS);

    localparam logic [AW:0]   CELLS_W    = (AW+1)'(CELLS);
    localparam logic [AW-1:0] LAST_ROW_A = AW'(LAST_ROW);
    localparam logic [AW-1:0] LAST_CELL  = AW'(CELLS - 1);
    localparam logic [CW-1:0] LAST_COL   = CW'(COLUMNS - 1);

    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_READ   = 3'd2;
    localparam logic [2:0] ST_SCROLL = 3'd3;
    localparam logic [2:0] ST_DRAIN  = 3'd4;

    logic [2:0]    state_reg, state_next;
    logic [AW-1:0] cursor_reg, cursor_next;
    logic [AW-1:0] floor_reg, floor_next;
    logic [AW-1:0] rowstart_reg, rowstart_next;
    logic [CW-1:0] col_reg, col_next;
    logic [AW-1:0] scan_reg, scan_next;
    logic          pend_valid_reg, pend_valid_next;
    logic          pend_blank_reg;
    logic [AW-1:0] pend_addr_reg;
    logic          rd_oob_reg;
    logic          rsp_valid_reg, rsp_valid_next;
    rsp_t          rsp_reg, rsp_next;

    logic [15:0]   screen_mem [CELLS];
    logic [15:0]   rd_data;
    logic          mem_we;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [15:0]   mem_wdata;

    logic          req_accept;
    logic          is_print, is_newline, is_backspace;
    logic [AW:0]   cur_inc, nl_start, scan_up;
    logic [AW-1:0] put_addr;
    logic          do_scroll;

    // accept only when idle and the response slot is free or draining now
    assign req_stall  = !((state_reg == ST_IDLE) && (!rsp_valid_reg || !rsp_stall));
    assign req_accept = req_valid && !req_stall;
    assign rsp_valid  = rsp_valid_reg;
    assign rsp        = rsp_reg;

    assign is_print     = (req.req_type == REQ_PRINT);
    assign is_newline   = is_print && (req.char_code == CH_NEWLINE);
    assign is_backspace = is_print && (req.char_code == CH_BACKSPACE);

    assign cur_inc  = {1'b0, cursor_reg} + (AW+1)'(1);
    assign nl_start = {1'b0, rowstart_reg} + (AW+1)'(COLUMNS);
    assign scan_up  = {1'b0, scan_reg} + (AW+1)'(COLUMNS);
    assign put_addr = (is_backspace && (cursor_reg > floor_reg)) ?
                      cursor_reg - AW'(1) : cursor_reg;

    // screen memory, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            screen_mem[mem_waddr] <= mem_wdata;
        end
        rd_data <= screen_mem[mem_raddr];
    end

    // memory port steering
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = scan_reg;
        mem_wdata = BLANK_CELL;
        mem_raddr = '0;
        case (state_reg)
            ST_CLEAR:
            begin
                mem_we = 1'b1;
            end
            ST_IDLE:
            begin
                if (32'(req.cell_index) < CELLS)
                begin
                    mem_raddr = AW'(req.cell_index);
                end
                if (req_accept && is_print && !is_newline)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = put_addr;
                    mem_wdata = {req.color, is_backspace ? CH_SPACE : req.char_code};
                end
            end
            ST_SCROLL, ST_DRAIN:
            begin
                if (32'(scan_reg) < LAST_ROW)
                begin
                    mem_raddr = AW'(scan_up);
                end
                mem_we    = pend_valid_reg;
                mem_waddr = pend_addr_reg;
                mem_wdata = pend_blank_reg ? BLANK_CELL : rd_data;
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    // control, cursor tracking and response loading
    always_comb
    begin
        state_next      = state_reg;
        cursor_next     = cursor_reg;
        floor_next      = floor_reg;
        rowstart_next   = rowstart_reg;
        col_next        = col_reg;
        scan_next       = scan_reg;
        pend_valid_next = 1'b0;
        rsp_next        = rsp_reg;
        rsp_valid_next  = rsp_valid_reg && rsp_stall;
        do_scroll       = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                scan_next = scan_reg + AW'(1);
                if (scan_reg == LAST_CELL)
                begin
                    scan_next  = '0;
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (req_accept)
                begin
                    if (!is_print)
                    begin
                        state_next = ST_READ;
                    end
                    else if (is_newline)
                    begin
                        if (nl_start >= CELLS_W)
                        begin
                            do_scroll = 1'b1;
                        end
                        else
                        begin
                            cursor_next   = AW'(nl_start);
                            rowstart_next = AW'(nl_start);
                            floor_next    = AW'(nl_start + (AW+1)'(2));
                            col_next      = '0;
                        end
                    end
                    else if (is_backspace)
                    begin
                        if (cursor_reg > floor_reg)
                        begin
                            cursor_next = put_addr;
                            if (col_reg == '0)
                            begin
                                col_next      = LAST_COL;
                                rowstart_next = rowstart_reg - AW'(COLUMNS);
                            end
                            else
                            begin
                                col_next = col_reg - CW'(1);
                            end
                        end
                    end
                    else
                    begin
                        if (col_reg == LAST_COL)
                        begin
                            if (cur_inc >= CELLS_W)
                            begin
                                do_scroll = 1'b1;
                            end
                            else
                            begin
                                cursor_next   = AW'(cur_inc);
                                rowstart_next = AW'(cur_inc);
                                floor_next    = AW'(cur_inc);
                                col_next      = '0;
                            end
                        end
                        else
                        begin
                            cursor_next = AW'(cur_inc);
                            col_next    = col_reg + CW'(1);
                        end
                    end

                    // scroll: park cursor at the last row and start the sweep
                    if (do_scroll)
                    begin
                        cursor_next   = LAST_ROW_A;
                        floor_next    = LAST_ROW_A;
                        rowstart_next = LAST_ROW_A;
                        col_next      = '0;
                        scan_next     = '0;
                        state_next    = ST_SCROLL;
                    end
                    else if (is_print)
                    begin
                        rsp_next.read_char  = '0;
                        rsp_next.read_attr  = '0;
                        rsp_next.cursor_now = CURSOR_W'(cursor_next);
                        rsp_next.scrolled   = 1'b0;
                        rsp_valid_next      = 1'b1;
                    end
                end
            end
            ST_READ:
            begin
                rsp_next.read_char  = rd_oob_reg ? 8'd0 : rd_data[7:0];
                rsp_next.read_attr  = rd_oob_reg ? 8'd0 : rd_data[15:8];
                rsp_next.cursor_now = CURSOR_W'(cursor_reg);
                rsp_next.scrolled   = 1'b0;
                rsp_valid_next      = 1'b1;
                state_next          = ST_IDLE;
            end
            ST_SCROLL:
            begin
                pend_valid_next = 1'b1;
                scan_next       = scan_reg + AW'(1);
                if (scan_reg == LAST_CELL)
                begin
                    scan_next  = scan_reg;
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                rsp_next.read_char  = '0;
                rsp_next.read_attr  = '0;
                rsp_next.cursor_now = CURSOR_W'(cursor_reg);
                rsp_next.scrolled   = 1'b1;
                rsp_valid_next      = 1'b1;
                scan_next           = '0;
                state_next          = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            cursor_reg     <= '0;
            floor_reg      <= '0;
            rowstart_reg   <= '0;
            col_reg        <= '0;
            scan_reg       <= '0;
            pend_valid_reg <= 1'b0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cursor_reg     <= cursor_next;
            floor_reg      <= floor_next;
            rowstart_reg   <= rowstart_next;
            col_reg        <= col_next;
            scan_reg       <= scan_next;
            pend_valid_reg <= pend_valid_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        rsp_reg        <= rsp_next;
        pend_addr_reg  <= scan_reg;
        pend_blank_reg <= (32'(scan_reg) >= LAST_ROW);
        if (req_accept)
        begin
            rd_oob_reg <= (32'(req.cell_index) >= CELLS);
        end
    end

    // cursor always on screen
    assert property (@(posedge clk) disable iff (!rst_n) 32'(cursor_reg) < CELLS)
        else $error("cursor left the screen");

    // column and row start stay consistent with the cursor
    assert property (@(posedge clk) disable iff (!rst_n)
        32'(cursor_reg) == 32'(rowstart_reg) + 32'(col_reg))
        else $error("cursor, row start and column disagree");

    // a scroll response always reports the last row start
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.scrolled) |-> (rsp.cursor_now == CURSOR_W'(LAST_ROW)))
        else $error("scroll response with wrong cursor");

    // clearing pass runs once after reset
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_CLEAR) |=> (state_reg != ST_CLEAR))
        else $error("clearing pass restarted");

    // scroll copy never writes the cell it is reading
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCROLL && pend_valid_reg && 32'(scan_reg) < LAST_ROW)
        |-> (mem_waddr != mem_raddr))
        else $error("scroll copy write/read collision");

endmodule

FILE: verif/tb_text_console_writer_top.sv
// Self-checking testbench for text_console_writer_top: printing, backspace,
// newline, scrolling and cell reads, checked against an in-bench screen mirror.
// Depends on tcw_pkg and the text_console_writer_top RTL.
module tb_text_console_writer_top
    import tcw_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CELLS      = COLUMNS_DEF * ROWS_DEF;
    localparam int LAST_ROW   = (ROWS_DEF - 1) * COLUMNS_DEF;
    localparam int N_RANDOM   = 1550;
    localparam int QUIET_TAIL = 150;
    // ~30 scrolls plus worst gaps/stalls per item stay well under
    // the limit, which leaves a wide margin over that run
    localparam int LIMIT      = 2000000;

    typedef struct {
        req_t rq;
        int   reps;
        bit   typed;
        rsp_t want;
    } step_row_t;

    logic clk = 1'b0;
    logic rst_n;
    logic req_valid;
    logic req_stall;
    req_t req;
    logic rsp_valid;
    logic rsp_stall;
    rsp_t rsp;

    // screen mirror, cursor and floor
    logic [15:0] screen_mirror [0:CELLS-1];
    int          mirror_cursor;
    int          floor_pos;

    rsp_t      rsp_pending [$];
    step_row_t steps [$];
    int        n_fail = 0;
    int        cycles = 0;
    bit        quiet  = 1'b0;

    text_console_writer_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always #1 clk = ~clk;

    // watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic req_t mk_req(logic rt, logic [7:0] ch, logic [7:0] col,
                                    logic [INDEX_W-1:0] idx);
        req_t r;
        r.req_type   = rt;
        r.char_code  = ch;
        r.color      = col;
        r.cell_index = idx;
        return r;
    endfunction

    // rows move up one, last row goes blank, cursor and floor to last row start
    function automatic void scroll_mirror();
        for (int i = 0; i < LAST_ROW; i++)
            screen_mirror[i] = screen_mirror[i + COLUMNS_DEF];
        for (int i = LAST_ROW; i < CELLS; i++)
            screen_mirror[i] = BLANK_CELL;
        mirror_cursor = LAST_ROW;
        floor_pos     = LAST_ROW;
    endfunction

    // advance the mirror by one request and return the response it implies
    function automatic rsp_t apply_request(req_t r);
        rsp_t o;
        o = '0;
        if (r.req_type == REQ_READ)
        begin
            if (r.cell_index < CELLS)
            begin
                o.read_char = screen_mirror[r.cell_index][7:0];
                o.read_attr = screen_mirror[r.cell_index][15:8];
            end
        end
        else if (r.char_code == CH_NEWLINE)
        begin
            mirror_cursor = (mirror_cursor / COLUMNS_DEF + 1) * COLUMNS_DEF;
            floor_pos     = mirror_cursor + 2;
            if (mirror_cursor >= CELLS)
            begin
                scroll_mirror();
                o.scrolled = 1'b1;
            end
        end
        else if (r.char_code == CH_BACKSPACE)
        begin
            if (mirror_cursor > floor_pos)
                mirror_cursor--;
            screen_mirror[mirror_cursor] = {r.color, CH_SPACE};
        end
        else
        begin
            screen_mirror[mirror_cursor] = {r.color, r.char_code};
            mirror_cursor++;
            if (mirror_cursor % COLUMNS_DEF == 0)
                floor_pos = mirror_cursor;
            if (mirror_cursor >= CELLS)
            begin
                scroll_mirror();
                o.scrolled = 1'b1;
            end
        end
        o.cursor_now = mirror_cursor[CURSOR_W-1:0];
        return o;
    endfunction

    // read address: near the cursor, anywhere, out of range, or a row edge
    function automatic logic [INDEX_W-1:0] pick_read_index();
        int idx;
        case ($urandom_range(0, 3))
            0: idx = mirror_cursor - int'($urandom_range(0, 4));
            1: idx = $urandom_range(0, CELLS - 1);
            2: idx = $urandom_range(CELLS, 2 ** INDEX_W - 1);
            default:
            begin
                case ($urandom_range(0, 5))
                    0: idx = 0;
                    1: idx = COLUMNS_DEF - 1;
                    2: idx = COLUMNS_DEF;
                    3: idx = LAST_ROW - 1;
                    4: idx = LAST_ROW;
                    default: idx = CELLS - 1;
                endcase
            end
        endcase
        if (idx < 0)
            idx = 0;
        return idx[INDEX_W-1:0];
    endfunction

    function automatic req_t rand_print(logic [7:0] ch);
        return mk_req(REQ_PRINT, ch, 8'($urandom_range(0, 255)),
                      INDEX_W'($urandom_range(0, 2 ** INDEX_W - 1)));
    endfunction

    function automatic req_t rand_read();
        return mk_req(REQ_READ, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                      pick_read_index());
    endfunction

    task automatic add_row(req_t rq, int reps, bit typed, rsp_t want);
        step_row_t s;
        s.rq    = rq;
        s.reps  = reps;
        s.typed = typed;
        s.want  = want;
        steps.push_back(s);
    endtask

    // one request transfer; the mirror is advanced at the accepting edge
    task automatic send_item(req_t r, bit typed, rsp_t want);
        int   gap;
        rsp_t got;
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 16);
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= r;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        got = apply_request(r);
        rsp_pending.push_back(typed ? want : got);
    endtask

    // hold off until every pending response is back
    task automatic drain();
        req_valid <= 1'b0;
        @(posedge clk);
        while (rsp_pending.size() != 0)
            @(posedge clk);
    endtask

    task automatic cmp_field(string fname, int unsigned expv, int unsigned gotv);
        if (expv != gotv)
        begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", fname, expv, gotv);
            n_fail++;
        end
    endtask

    // response side stall bursts
    initial
    begin
        int stall_left;
        stall_left = 0;
        rsp_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (!quiet && stall_left == 0 && $urandom_range(0, 7) == 0)
                stall_left = $urandom_range(1, 16);
            if (!quiet && stall_left > 0)
            begin
                rsp_stall <= 1'b1;
                stall_left--;
            end
            else
            begin
                rsp_stall <= 1'b0;
                stall_left = 0;
            end
        end
    end

    // response checker
    always @(posedge clk)
    begin : rsp_check
        rsp_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (rsp_pending.size() == 0)
            begin
                $error("response with none pending: 0x%0h", rsp);
                n_fail++;
            end
            else
            begin
                want = rsp_pending.pop_front();
                cmp_field("read_char", 32'(want.read_char), 32'(rsp.read_char));
                cmp_field("read_attr", 32'(want.read_attr), 32'(rsp.read_attr));
                cmp_field("cursor_now", 32'(want.cursor_now), 32'(rsp.cursor_now));
                cmp_field("scrolled", 32'(want.scrolled), 32'(rsp.scrolled));
            end
        end
    end

    initial
    begin
        int stop_at;
        int n_sent;
        int len;
        int n_bs;
        int next_drain;

        rst_n     = 1'b0;
        req_valid = 1'b0;
        req       = '0;
        for (int i = 0; i < CELLS; i++)
            screen_mirror[i] = BLANK_CELL;
        mirror_cursor = 0;
        floor_pos     = 0;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // directed rows: reset contents, out-of-range reads, floor cases, scroll
        add_row(mk_req(REQ_READ, 8'h00, 8'h00, 11'd0), 1, 1'b1, '{8'h20, 8'h07, 11'd0, 1'b0});
        add_row(mk_req(REQ_READ, 8'h00, 8'h00, 11'd1999), 1, 1'b1,
                '{8'h20, 8'h07, 11'd0, 1'b0});
        add_row(mk_req(REQ_READ, 8'hFF, 8'hFF, 11'd2000), 1, 1'b1,
                '{8'h00, 8'h00, 11'd0, 1'b0});
        add_row(mk_req(REQ_READ, 8'hFF, 8'hFF, 11'd2047), 1, 1'b1,
                '{8'h00, 8'h00, 11'd0, 1'b0});
        // backspace at the floor still blanks the cell
        add_row(mk_req(REQ_PRINT, CH_BACKSPACE, 8'hFF, 11'd0), 1, 1'b1,
                '{8'h00, 8'h00, 11'd0, 1'b0});
        add_row(mk_req(REQ_READ, 8'h00, 8'h00, 11'd0), 1, 1'b1, '{8'h20, 8'hFF, 11'd0, 1'b0});
        add_row(mk_req(REQ_PRINT, 8'h41, 8'h1E, 11'd0), 1, 1'b1,
                '{8'h00, 8'h00, 11'd1, 1'b0});
        add_row(mk_req(REQ_PRINT, 8'hFF, 8'h00, 11'd2047), 1, 1'b1,
                '{8'h00, 8'h00, 11'd2, 1'b0});
        add_row(mk_req(REQ_PRINT, 8'h00, 8'hFF, 11'd0), 1, 1'b1,
                '{8'h00, 8'h00, 11'd3, 1'b0});
        add_row(mk_req(REQ_PRINT, CH_BACKSPACE, 8'h5A, 11'd0), 1, 1'b0, '0);
        add_row(mk_req(REQ_READ, 8'h00, 8'h00, 11'd2), 1, 1'b0, '0);
        add_row(mk_req(REQ_PRINT, CH_NEWLINE, 8'h00, 11'd0), 1, 1'b1,
                '{8'h00, 8'h00, 11'd80, 1'b0});
        // cursor below the floor after newline: backspace does not move it
        add_row(mk_req(REQ_PRINT, CH_BACKSPACE, 8'h81, 11'd0), 1, 1'b0, '0);
        add_row(mk_req(REQ_PRINT, 8'h78, 8'h3C, 11'd0), 2, 1'b0, '0);
        add_row(mk_req(REQ_PRINT, CH_BACKSPACE, 8'h42, 11'd0), 1, 1'b0, '0);
        add_row(mk_req(REQ_READ, 8'h00, 8'h00, 11'd82), 1, 1'b0, '0);
        add_row(mk_req(REQ_PRINT, CH_NEWLINE, 8'h00, 11'd0), 23, 1'b0, '0);
        // newline on the last row scrolls; floor lands on the last row start
        add_row(mk_req(REQ_PRINT, CH_NEWLINE, 8'h00, 11'd0), 1, 1'b1,
                '{8'h00, 8'h00, 11'd1920, 1'b1});
        add_row(mk_req(REQ_READ, 8'h00, 8'h00, 11'd1999), 1, 1'b1,
                '{8'h20, 8'h07, 11'd1920, 1'b0});
        add_row(mk_req(REQ_READ, 8'h00, 8'h00, 11'd0), 1, 1'b0, '0);
        add_row(mk_req(REQ_PRINT, CH_BACKSPACE, 8'h33, 11'd0), 1, 1'b0, '0);
        add_row(mk_req(REQ_PRINT, 8'h7F, 8'h80, 11'd0), 3, 1'b0, '0);
        add_row(mk_req(REQ_READ, 8'h00, 8'h00, 11'd1919), 1, 1'b0, '0);

        foreach (steps[i])
            repeat (steps[i].reps)
                send_item(steps[i].rq, steps[i].typed, steps[i].want);

        drain();

        // random traffic: mostly typed lines with edits, plus reads and noise
        n_sent     = 0;
        stop_at    = N_RANDOM;
        next_drain = 500;
        while (n_sent < stop_at)
        begin
            if (n_sent >= stop_at - QUIET_TAIL)
                quiet = 1'b1;
            if (n_sent >= next_drain)
            begin
                drain();
                next_drain += 500;
            end
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4:
                begin
                    len = $urandom_range(1, 24);
                    for (int k = 0; k < len; k++)
                    begin
                        if ($urandom_range(0, 3) == 0)
                            send_item(rand_read(), 1'b0, '0);
                        else
                            send_item(rand_print(8'($urandom_range(0, 255))), 1'b0, '0);
                        n_sent++;
                    end
                    if ($urandom_range(0, 2) == 0)
                    begin
                        n_bs = $urandom_range(1, len + 4);
                        for (int k = 0; k < n_bs; k++)
                        begin
                            send_item(rand_print(CH_BACKSPACE), 1'b0, '0);
                            n_sent++;
                        end
                    end
                    if ($urandom_range(0, 3) == 0)
                    begin
                        send_item(rand_print(CH_NEWLINE), 1'b0, '0);
                        n_sent++;
                    end
                end
                5, 6, 7:
                begin
                    len = $urandom_range(1, 6);
                    for (int k = 0; k < len; k++)
                    begin
                        send_item(rand_read(), 1'b0, '0);
                        n_sent++;
                    end
                end
                8:
                begin
                    send_item(mk_req(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                                     8'($urandom_range(0, 255)),
                                     INDEX_W'($urandom_range(0, 2 ** INDEX_W - 1))),
                              1'b0, '0);
                    n_sent++;
                end
                default:
                begin
                    len = $urandom_range(1, 8);
                    for (int k = 0; k < len; k++)
                    begin
                        send_item(rand_print(CH_BACKSPACE), 1'b0, '0);
                        n_sent++;
                    end
                end
            endcase
        end

        drain();
        repeat (16) @(posedge clk);

        if (n_fail == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

FILE: sim.f
rtl/core/tcw_pkg.sv
rtl/core/text_console_writer_top.sv
verif/tb_text_console_writer_top.sv
